[hdl/brlt_pkg.sv]
// Shared types and constants for the byte-range lock table.
// Holds table geometry, request/status codes, entry and match structs.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package brlt_pkg;

   localparam int MAX_LOCKS = 16;
   localparam int IDX_W     = (MAX_LOCKS > 1) ? $clog2(MAX_LOCKS) : 1;
   localparam int CNT_W     = $clog2(MAX_LOCKS + 1);

   // resolved start: 32-bit unsigned base plus 32-bit signed offset
   localparam int RS_W = 34;
   // resolved end: resolved start plus 32-bit unsigned length
   localparam int RE_W = 35;

   localparam logic [1:0] WH_POS = 2'd1;
   localparam logic [1:0] WH_LEN = 2'd2;

   localparam logic LOCK_WRITE = 1'b1;

   typedef enum logic [1:0] {
      MODE_LOCK   = 2'd0,
      MODE_UNLOCK = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_BAD    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_BAD_START = 3'd1,
      STS_DENIED    = 3'd2,
      STS_CONFLICT  = 3'd3,
      STS_NOT_FOUND = 3'd4,
      STS_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_WRITE,
      S_RESP
   } fsm_type;

   typedef struct packed {
      logic            lk_type;
      logic [1:0]      whence;
      logic [31:0]     raw_start;
      logic [31:0]     length;
      logic [15:0]     owner;
      logic [RS_W-1:0] rstart;
      logic [RE_W-1:0] rend;
   } lock_entry_type;

   typedef struct packed {
      logic            lk_type;
      logic [1:0]      whence;
      logic [31:0]     raw_start;
      logic [31:0]     length;
      logic [15:0]     owner;
      logic [RS_W-1:0] rstart;
   } req_info_type;

   typedef struct packed {
      logic conflict;
      logic same;
   } match_type;

endpackage

[hdl/byte_range_lock_table_top.sv]
// Byte-range lock table, top level: request sequencer, entry store, comparator.
// Depends on brlt_pkg, brlt_table and brlt_match.
//
// The block keeps up to MAX_LOCKS (16) read/write byte-range locks and serves
// one request at a time: set a lock, remove one, or report the first lock that
// blocks a given range. A request's start is resolved against zero, the file
// position or the file length on acceptance. The sequencer then walks the
// table from slot 0 upward through a single read port and one shared
// comparator, one slot per cycle, comparing each slot once its registered read
// data is back; a lock that passes every check then goes through a write
// state that puts its entry into the lowest free slot. A lock without
// permission or a request with mode three skips the walk and goes straight to
// its result. The walk stops at the first conflict or unlock match. Exactly one
// result follows each request, and req_tready stays low from acceptance until
// that result has been taken. Status is carried on rsp_tuser; the blocker
// fields are zero unless a query found a conflicting entry. The table starts
// empty after reset with no clearing pass.
module byte_range_lock_table_top (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata, from bit 0: lock_type[0], whence[2:1], start_offset[34:3],
   // range_length[66:35], owner_id[82:67], file_position[114:83],
   // file_length[146:115], permitted[147], zero fill[151:148]
   input  logic [151:0] req_tdata,
   // tuser: mode[1:0]
   input  logic [1:0]   req_tuser,
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata, from bit 0: blocker_found[0], blocker_type[1], blocker_whence[3:2],
   // blocker_start[35:4], blocker_length[67:36], blocker_owner[83:68],
   // zero fill[87:84]
   output logic [87:0]  rsp_tdata,
   // tuser: status[2:0]
   output logic [2:0]   rsp_tuser
);

   localparam int NL   = brlt_pkg::MAX_LOCKS;
   localparam int IW   = brlt_pkg::IDX_W;
   localparam int CW   = brlt_pkg::CNT_W;
   localparam int RS_W = brlt_pkg::RS_W;
   localparam int RE_W = brlt_pkg::RE_W;

   // request fields as unpacked from the bus
   brlt_pkg::mode_type  in_mode;
   logic                in_type;
   logic [1:0]          in_whence;
   logic [31:0]         in_start;
   logic [31:0]         in_length;
   logic [15:0]         in_owner;
   logic [31:0]         in_fpos;
   logic [31:0]         in_flen;
   logic                in_permitted;
   logic [31:0]         in_base;
   logic [RS_W-1:0]     in_rstart;

   assign in_mode      = brlt_pkg::mode_type'(req_tuser);
   assign in_type      = req_tdata[0];
   assign in_whence    = req_tdata[2:1];
   assign in_start     = req_tdata[34:3];
   assign in_length    = req_tdata[66:35];
   assign in_owner     = req_tdata[82:67];
   assign in_fpos      = req_tdata[114:83];
   assign in_flen      = req_tdata[146:115];
   assign in_permitted = req_tdata[147];

   // pick the base; whence three resolves against zero
   always_comb begin
      case (in_whence)
         brlt_pkg::WH_POS: in_base = in_fpos;
         brlt_pkg::WH_LEN: in_base = in_flen;
         default:          in_base = '0;
      endcase
   end

   assign in_rstart = {2'b00, in_base} + {{(RS_W-32){in_start[31]}}, in_start};

   // sequencer state
   brlt_pkg::fsm_type      state_ff,    state_in;
   brlt_pkg::mode_type     mode_ff,     mode_in;
   brlt_pkg::req_info_type req_ff,      req_in;
   logic [CW-1:0]          rd_cnt_ff,   rd_cnt_in;
   logic                   cmp_vld_ff,  cmp_vld_in;
   logic [IW-1:0]          cmp_idx_ff,  cmp_idx_in;
   logic                   free_vld_ff, free_vld_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   logic [NL-1:0]          valid_ff,    valid_in;
   brlt_pkg::status_type   status_ff,   status_in;
   logic                   found_ff,    found_in;
   logic                   blk_type_ff, blk_type_in;
   logic [1:0]             blk_whence_ff, blk_whence_in;
   logic [31:0]            blk_start_ff,  blk_start_in;
   logic [31:0]            blk_length_ff, blk_length_in;
   logic [15:0]            blk_owner_ff,  blk_owner_in;

   // table and comparator hookup
   logic                     rd_en;
   logic [IW-1:0]            rd_idx;
   logic                     wr_en;
   brlt_pkg::lock_entry_type wr_data;
   brlt_pkg::lock_entry_type rd_data;
   brlt_pkg::match_type      cmp_res;
   logic [RE_W-1:0]          req_rend;

   // request end, exclusive: resolved start plus length
   assign req_rend = {req_ff.rstart[RS_W-1], req_ff.rstart} + {3'b000, req_ff.length};

   brlt_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (free_idx_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_data (rd_data)
   );

   brlt_match u_match (
      .req      (req_ff),
      .req_rend (req_rend),
      .ent      (rd_data),
      .res      (cmp_res)
   );

   always_comb begin
      wr_data.lk_type   = req_ff.lk_type;
      wr_data.whence    = req_ff.whence;
      wr_data.raw_start = req_ff.raw_start;
      wr_data.length    = req_ff.length;
      wr_data.owner     = req_ff.owner;
      wr_data.rstart    = req_ff.rstart;
      wr_data.rend      = req_rend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= brlt_pkg::S_IDLE;
         valid_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      req_ff        <= req_in;
      rd_cnt_ff     <= rd_cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_vld_ff   <= free_vld_in;
      free_idx_ff   <= free_idx_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      blk_type_ff   <= blk_type_in;
      blk_whence_ff <= blk_whence_in;
      blk_start_ff  <= blk_start_in;
      blk_length_ff <= blk_length_in;
      blk_owner_ff  <= blk_owner_in;
   end

   logic cur_valid;
   logic hit;
   logic last;

   assign cur_valid = valid_ff[cmp_idx_ff];
   assign last      = (cmp_idx_ff == IW'(NL - 1));

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      req_in        = req_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      free_vld_in   = free_vld_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      blk_type_in   = blk_type_ff;
      blk_whence_in = blk_whence_ff;
      blk_start_in  = blk_start_ff;
      blk_length_in = blk_length_ff;
      blk_owner_in  = blk_owner_ff;
      rd_en         = 1'b0;
      rd_idx        = rd_cnt_ff[IW-1:0];
      wr_en         = 1'b0;
      hit           = 1'b0;
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;

      unique case (state_ff)
         brlt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // latch the request and clear the blocker fields
               mode_in           = in_mode;
               req_in.lk_type    = in_type;
               req_in.whence     = in_whence;
               req_in.raw_start  = in_start;
               req_in.length     = in_length;
               req_in.owner      = in_owner;
               req_in.rstart     = in_rstart;
               rd_cnt_in         = '0;
               free_vld_in       = 1'b0;
               found_in          = 1'b0;
               blk_type_in       = 1'b0;
               blk_whence_in     = '0;
               blk_start_in      = '0;
               blk_length_in     = '0;
               blk_owner_in      = '0;
               if (in_mode == brlt_pkg::MODE_BAD) begin
                  status_in = brlt_pkg::STS_BAD_START;
                  state_in  = brlt_pkg::S_RESP;
               end else if (in_mode == brlt_pkg::MODE_LOCK && !in_permitted) begin
                  status_in = brlt_pkg::STS_DENIED;
                  state_in  = brlt_pkg::S_RESP;
               end else begin
                  state_in  = brlt_pkg::S_SCAN;
               end
            end
         end

         brlt_pkg::S_SCAN: begin
            // issue one read per cycle, compare the slot read last cycle
            rd_en      = (rd_cnt_ff < CW'(NL));
            rd_cnt_in  = rd_cnt_ff + CW'(rd_en);
            cmp_vld_in = rd_en;
            cmp_idx_in = rd_cnt_ff[IW-1:0];

            if (cmp_vld_ff) begin
               // remember the lowest free slot for an insert
               if (!cur_valid && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end

               if (mode_ff == brlt_pkg::MODE_UNLOCK) begin
                  hit = cur_valid && cmp_res.same;
               end else begin
                  hit = cur_valid && cmp_res.conflict;
               end

               if (hit) begin
                  cmp_vld_in = 1'b0;
                  state_in   = brlt_pkg::S_RESP;
                  unique case (mode_ff)
                     brlt_pkg::MODE_LOCK: begin
                        status_in = brlt_pkg::STS_CONFLICT;
                     end
                     brlt_pkg::MODE_UNLOCK: begin
                        valid_in[cmp_idx_ff] = 1'b0;
                        status_in = brlt_pkg::STS_OK;
                     end
                     default: begin
                        status_in     = brlt_pkg::STS_OK;
                        found_in      = 1'b1;
                        blk_type_in   = rd_data.lk_type;
                        blk_whence_in = rd_data.whence;
                        blk_start_in  = rd_data.raw_start;
                        blk_length_in = rd_data.length;
                        blk_owner_in  = rd_data.owner;
                     end
                  endcase
               end else if (last) begin
                  cmp_vld_in = 1'b0;
                  state_in   = brlt_pkg::S_RESP;
                  unique case (mode_ff)
                     brlt_pkg::MODE_LOCK: begin
                        if (req_ff.rstart[RS_W-1]) begin
                           status_in = brlt_pkg::STS_BAD_START;
                        end else if (!free_vld_in) begin
                           status_in = brlt_pkg::STS_FULL;
                        end else begin
                           state_in  = brlt_pkg::S_WRITE;
                        end
                     end
                     brlt_pkg::MODE_UNLOCK: begin
                        status_in = brlt_pkg::STS_NOT_FOUND;
                     end
                     default: begin
                        status_in = brlt_pkg::STS_OK;
                     end
                  endcase
               end
            end
         end

         brlt_pkg::S_WRITE: begin
            wr_en                 = 1'b1;
            valid_in[free_idx_ff] = 1'b1;
            status_in             = brlt_pkg::STS_OK;
            state_in              = brlt_pkg::S_RESP;
         end

         brlt_pkg::S_RESP: begin
            // hold the result until the transfer completes
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = brlt_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = brlt_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {4'b0000, blk_owner_ff, blk_length_ff, blk_start_ff,
                       blk_whence_ff, blk_type_ff, found_ff};

endmodule

[hdl/brlt_table.sv]
// Lock entry storage: one write port, one read port with registered data.
// Uses brlt_pkg for the entry struct and table depth.
module brlt_table (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [brlt_pkg::IDX_W-1:0]    wr_idx,
   input  brlt_pkg::lock_entry_type      wr_data,
   input  logic                          rd_en,
   input  logic [brlt_pkg::IDX_W-1:0]    rd_idx,
   output brlt_pkg::lock_entry_type      rd_data
);

   brlt_pkg::lock_entry_type mem_ff [brlt_pkg::MAX_LOCKS];
   brlt_pkg::lock_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/brlt_match.sv]
// Shared entry comparator: range overlap with write/read conflict rule,
// and exact-key match for unlock. Uses brlt_pkg structs and widths.
module brlt_match (
   input  brlt_pkg::req_info_type              req,
   input  logic [brlt_pkg::RE_W-1:0]           req_rend,
   input  brlt_pkg::lock_entry_type            ent,
   output brlt_pkg::match_type                 res
);

   logic signed [brlt_pkg::RE_W-1:0] req_s;
   logic signed [brlt_pkg::RE_W-1:0] req_e;
   logic signed [brlt_pkg::RE_W-1:0] ent_s;
   logic signed [brlt_pkg::RE_W-1:0] ent_e;
   logic                             overlap;

   assign req_s = $signed({req.rstart[brlt_pkg::RS_W-1], req.rstart});
   assign ent_s = $signed({ent.rstart[brlt_pkg::RS_W-1], ent.rstart});
   assign req_e = $signed(req_rend);
   assign ent_e = $signed(ent.rend);

   // end is exclusive on both sides
   assign overlap = (req_e > ent_s) && (ent_e > req_s);

   assign res.conflict = overlap &&
                         ((req.lk_type == brlt_pkg::LOCK_WRITE) ||
                          (ent.lk_type == brlt_pkg::LOCK_WRITE));

   assign res.same = (ent.raw_start == req.raw_start) &&
                     (ent.whence == req.whence) &&
                     (ent.length == req.length) &&
                     (ent.owner == req.owner);

endmodule

[hdl/brlt_checker.sv]
// Port-level checker for the byte-range lock table, bound to the top level.
// Depends on brlt_pkg for status codes and on byte_range_lock_table_top.
module brlt_port_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [151:0] req_tdata,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [87:0]  rsp_tdata,
   input logic [2:0]   rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // one request in flight: no new transfer while a result waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a result is pending");

   // busy right after a request transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready stayed high after a request transfer");

   // a reported blocker comes with status ok
   a_blocker_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser == brlt_pkg::STS_OK)
      else $error("blocker reported with non-ok status");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= brlt_pkg::STS_FULL)
      else $error("undefined status code");

endmodule

bind byte_range_lock_table_top brlt_port_checker u_brlt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[verif/brlt_checker.sv]
// Scoreboard for the byte-range lock table: keeps a shadow lock table, predicts
// one response per request transfer and compares it field by field.
// Depends on brlt_pkg for the table size and the mode and status codes.
module brlt_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [151:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [87:0]  rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   output int           mismatch_count,
   output int           outstanding
);

   typedef struct packed {
      brlt_pkg::status_type status;
      logic        found;
      logic        btype;
      logic [1:0]  bwhence;
      logic [31:0] bstart;
      logic [31:0] blength;
      logic [15:0] bowner;
   } lock_result_type;

   // shadow copy of the lock table
   logic        held_valid  [brlt_pkg::MAX_LOCKS];
   logic        held_type   [brlt_pkg::MAX_LOCKS];
   logic [1:0]  held_whence [brlt_pkg::MAX_LOCKS];
   logic [31:0] held_raw    [brlt_pkg::MAX_LOCKS];
   logic [31:0] held_len    [brlt_pkg::MAX_LOCKS];
   logic [15:0] held_owner  [brlt_pkg::MAX_LOCKS];
   logic [31:0] held_base   [brlt_pkg::MAX_LOCKS];

   lock_result_type pending_results[$];
   int errors = 0;

   function automatic longint resolve_start(logic [31:0] base, logic [31:0] raw);
      return longint'(base) + longint'($signed(raw));
   endfunction

   function automatic bit spans_overlap(longint sa, logic [31:0] la,
                                        longint sb, logic [31:0] lb);
      return (sa + longint'(la) > sb) && (sb + longint'(lb) > sa);
   endfunction

   // lowest held lock that blocks the given range, or -1
   function automatic int first_blocker(logic wr, longint s, logic [31:0] l);
      for (int i = 0; i < brlt_pkg::MAX_LOCKS; i++) begin
         if (held_valid[i] && (wr || held_type[i] == brlt_pkg::LOCK_WRITE) &&
             spans_overlap(s, l, resolve_start(held_base[i], held_raw[i]), held_len[i]))
            return i;
      end
      return -1;
   endfunction

   // apply one request to the shadow table and return its response
   function automatic lock_result_type serve_request(logic [1:0] mode, logic [151:0] d);
      logic         wr;
      logic [1:0]   wh;
      logic [31:0]  raw, len, fpos, flen, base;
      logic [15:0]  owner;
      logic         perm;
      longint       start;
      int           slot;
      lock_result_type res;
      wr    = d[0];
      wh    = d[2:1];
      raw   = d[34:3];
      len   = d[66:35];
      owner = d[82:67];
      fpos  = d[114:83];
      flen  = d[146:115];
      perm  = d[147];
      base  = (wh == brlt_pkg::WH_POS) ? fpos : (wh == brlt_pkg::WH_LEN) ? flen : 32'd0;
      start = resolve_start(base, raw);
      res   = '0;
      res.status = brlt_pkg::STS_OK;
      case (brlt_pkg::mode_type'(mode))
         brlt_pkg::MODE_LOCK: begin
            if (!perm)
               res.status = brlt_pkg::STS_DENIED;
            else if (first_blocker(wr, start, len) >= 0)
               res.status = brlt_pkg::STS_CONFLICT;
            else if (start < 0)
               res.status = brlt_pkg::STS_BAD_START;
            else begin
               slot = -1;
               for (int i = brlt_pkg::MAX_LOCKS - 1; i >= 0; i--)
                  if (!held_valid[i]) slot = i;
               if (slot < 0)
                  res.status = brlt_pkg::STS_FULL;
               else begin
                  held_valid[slot]  = 1'b1;
                  held_type[slot]   = wr;
                  held_whence[slot] = wh;
                  held_raw[slot]    = raw;
                  held_len[slot]    = len;
                  held_owner[slot]  = owner;
                  held_base[slot]   = base;
               end
            end
         end
         brlt_pkg::MODE_UNLOCK: begin
            // free only the lowest exact match
            res.status = brlt_pkg::STS_NOT_FOUND;
            for (int i = 0; i < brlt_pkg::MAX_LOCKS; i++) begin
               if (res.status == brlt_pkg::STS_NOT_FOUND && held_valid[i] &&
                   held_raw[i] == raw && held_whence[i] == wh && held_len[i] == len &&
                   held_owner[i] == owner) begin
                  held_valid[i] = 1'b0;
                  res.status    = brlt_pkg::STS_OK;
               end
            end
         end
         brlt_pkg::MODE_QUERY: begin
            slot = first_blocker(wr, start, len);
            if (slot >= 0) begin
               res.found   = 1'b1;
               res.btype   = held_type[slot];
               res.bwhence = held_whence[slot];
               res.bstart  = held_raw[slot];
               res.blength = held_len[slot];
               res.bowner  = held_owner[slot];
            end
         end
         default: res.status = brlt_pkg::STS_BAD_START;
      endcase
      return res;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      lock_result_type want;
      if (reset) begin
         for (int i = 0; i < brlt_pkg::MAX_LOCKS; i++) held_valid[i] = 1'b0;
         pending_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            pending_results.push_back(serve_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response transfer with no request outstanding");
               errors++;
            end else begin
               want = pending_results.pop_front();
               check_field("status",         32'(want.status),  32'(rsp_tuser));
               check_field("blocker_found",  32'(want.found),   32'(rsp_tdata[0]));
               check_field("blocker_type",   32'(want.btype),   32'(rsp_tdata[1]));
               check_field("blocker_whence", 32'(want.bwhence), 32'(rsp_tdata[3:2]));
               check_field("blocker_start",  want.bstart,       rsp_tdata[35:4]);
               check_field("blocker_length", want.blength,      rsp_tdata[67:36]);
               check_field("blocker_owner",  32'(want.bowner),  32'(rsp_tdata[83:68]));
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= pending_results.size();
   end

endmodule

[verif/tb.sv]
// Top of the lock table testbench: clock, reset, request stimulus, response
// backpressure and the final verdict. Depends on brlt_pkg, the block's top
// level byte_range_lock_table_top and the scoreboard brlt_checker.
module tb;

   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1500;
   // a request walks the table at most once; add sender gaps and response stalls, then
   // allow several times the slowest plausible run
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 25;
   localparam int HISTORY_MAX  = 64;

   typedef struct {
      brlt_pkg::mode_type mode;
      logic        wr;
      logic [1:0]  whence;
      logic [31:0] raw;
      logic [31:0] len;
      logic [15:0] owner;
      logic [31:0] fpos;
      logic [31:0] flen;
      logic        perm;
   } lock_request_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [151:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [87:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;

   int fail_total;
   int in_flight;
   int cycle_count = 0;
   int burst_left  = 0;
   int stall_left  = 0;
   int stall_odds  = 0;

   // most recent locks issued (up to HISTORY_MAX), replayed later as exact-match unlocks
   lock_request_type lock_history[$];

   always #2 clock = ~clock;

   byte_range_lock_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   brlt_checker lock_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (fail_total),
      .outstanding    (in_flight)
   );

   // Hard stop: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response backpressure: periodically pick a new stall rate (none up to heavy),
   // and hold ready low in runs of random length.
   always @(posedge clock) begin
      if (cycle_count % 256 == 0)
         stall_odds = $urandom_range(0, 3) * 15;
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_odds) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic lock_request_type make_request(brlt_pkg::mode_type m, logic wr,
                                                     logic [1:0] wh,
                                                     logic [31:0] raw, logic [31:0] len,
                                                     logic [15:0] owner, logic [31:0] fpos,
                                                     logic [31:0] flen, logic perm);
      lock_request_type r;
      r.mode   = m;
      r.wr     = wr;
      r.whence = wh;
      r.raw    = raw;
      r.len    = len;
      r.owner  = owner;
      r.fpos   = fpos;
      r.flen   = flen;
      r.perm   = perm;
      return r;
   endfunction

   // Well-formed request in a narrow window so that locks collide often:
   // resolved starts stay within a few hundred bytes, a few go negative.
   function automatic lock_request_type nearby_request(brlt_pkg::mode_type m);
      lock_request_type r;
      r.mode   = m;
      r.wr     = 1'($urandom_range(0, 1));
      r.whence = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      r.raw    = $urandom_range(0, 300) - 32'd40;
      r.len    = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 64));
      if ($urandom_range(0, 31) == 0) r.len = $urandom;
      r.owner  = 16'($urandom_range(0, 7));
      r.fpos   = $urandom_range(0, 200);
      r.flen   = $urandom_range(0, 200);
      r.perm   = ($urandom_range(0, 9) != 0);
      return r;
   endfunction

   // Drive one request, hold it until the transfer, then close the burst with a
   // random gap when its count runs out.
   task automatic send_request(input lock_request_type r);
      if (r.mode == brlt_pkg::MODE_LOCK) begin
         lock_history.push_back(r);
         if (lock_history.size() > HISTORY_MAX) void'(lock_history.pop_front());
      end
      req_tdata  <= {4'b0, r.perm, r.flen, r.fpos, r.owner, r.len, r.raw, r.whence, r.wr};
      req_tuser  <= r.mode;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         // mostly short bursts, now and then a long stretch without gaps
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
      end
   endtask

   initial begin
      lock_request_type r;
      int            sel;
      int            idx;
      repeat (RESET_CYCLES) @(posedge clock);
      reset      <= 1'b0;
      burst_left  = 6;

      // --- directed part ---
      // query and unlock on an empty table
      send_request(make_request(brlt_pkg::MODE_QUERY, 1, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_UNLOCK, 0, 0, 0, 0, 0, 0, 0, 1));
      // lock without permission, then the same lock granted
      send_request(make_request(brlt_pkg::MODE_LOCK, 1, 0, 100, 50, 1, 0, 0, 0));
      send_request(make_request(brlt_pkg::MODE_LOCK, 1, 0, 100, 50, 1, 0, 0, 1));
      // the owner's own write lock still blocks it
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, 0, 120, 10, 1, 0, 0, 1));
      // a touching range does not overlap; a zero length range starting inside
      // the write lock still does
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, 0, 150, 10, 2, 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_LOCK, 1, 0, 120, 0, 3, 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_QUERY, 0, 0, 0, 1000, 16'hFFFF, 0, 0, 0));
      // negative resolved start, absolute and from the file length, beside two valid ones
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, 0, 32'hFFFF_FFFB, 3, 7, 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_LOCK, 1, brlt_pkg::WH_POS, 32'hFFFF_FFF6,
                                5, 4, 1000, 0, 1));
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, brlt_pkg::WH_LEN, 32'h7FFF_FFFF,
                                32'hFFFF_FFFF, 16'hFFFF, 0, 32'hFFFF_FFFF, 1));
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, brlt_pkg::WH_LEN, 32'h8000_0000,
                                1, 8, 0, 0, 1));
      // whence three resolves against zero
      send_request(make_request(brlt_pkg::MODE_LOCK, 1, 2'd3, 500, 10, 5, 7777, 8888, 1));
      // mode three leaves the table untouched
      send_request(make_request(brlt_pkg::MODE_BAD, 1, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      // exact unlock, then one with the wrong owner
      send_request(make_request(brlt_pkg::MODE_UNLOCK, 1, 0, 100, 50, 1, 0, 0, 0));
      send_request(make_request(brlt_pkg::MODE_UNLOCK, 1, 2'd3, 500, 10, 6, 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_QUERY, 0, brlt_pkg::WH_POS, 12, 4, 9,
                                980, 0, 1));
      // fill the table with shared locks, then one more for the full status
      for (int i = 0; i < 12; i++)
         send_request(make_request(brlt_pkg::MODE_LOCK, 0, 0, 2000 + 16 * i, 8,
                                   16'(10 + i), 0, 0, 1));
      send_request(make_request(brlt_pkg::MODE_LOCK, 0, 0, 3000, 1, 30, 0, 0, 1));

      // --- random part ---
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         // once, hold off until every response is back
         if (k == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (in_flight != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            r = nearby_request(brlt_pkg::MODE_LOCK);
         end else if (sel < 65 && lock_history.size() > 0) begin
            // replay an earlier lock as an unlock; type and permission are don't-care
            idx = $urandom_range(0, lock_history.size() - 1);
            r   = lock_history[idx];
            lock_history.delete(idx);
            r.mode = brlt_pkg::MODE_UNLOCK;
            r.wr   = 1'($urandom_range(0, 1));
            r.perm = 1'($urandom_range(0, 1));
            r.fpos = $urandom;
            r.flen = $urandom;
         end else if (sel < 85) begin
            r = nearby_request(brlt_pkg::MODE_QUERY);
         end else begin
            // noise: every field over its full range, every mode
            r = make_request(brlt_pkg::mode_type'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)),
                             2'($urandom_range(0, 3)), $urandom, $urandom,
                             16'($urandom), $urandom, $urandom,
                             1'($urandom_range(0, 1)));
         end
         send_request(r);
      end

      // drain: wait for the last response, then give the block time to misbehave
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_total == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
